FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define EABB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define EABB_ASSERT_RAW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

FILE: hw/rtl/eabb_pkg.sv
package eabb_pkg;

    // CORDIC datapath width, point sum width, final box width
    localparam int CW = 34;
    localparam int W_PT = 46;
    localparam int W_F = 48;

    localparam int FRONT_STAGES = 4;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW = $clog2(Q_DEPTH);
    // front, queue store, queue output, and seven tail stages
    localparam int LAT_FIXED = FRONT_STAGES + 2 + 7;

    localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] ROT_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius_x;
        logic [30:0]        radius_y;
        logic signed [31:0] xform_a;
        logic signed [31:0] xform_b;
        logic signed [31:0] xform_c;
        logic signed [31:0] xform_d;
        logic signed [31:0] xform_e;
        logic signed [31:0] xform_f;
        logic               stroke_enabled;
        logic [30:0]        stroke_size;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] box_left;
        logic signed [31:0] box_top;
        logic [30:0]        box_width;
        logic [30:0]        box_height;
    } t_out_item;

    // Normalized vectoring seed of one extreme angle
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 den_zero;
        logic                 num_pos;
        logic                 num_neg;
    } t_seed;

    typedef struct packed {
        t_in_item    item;
        t_seed [1:0] lane;
    } t_seed_item;

    function automatic int steps_used(input int s);
        return (s > 32) ? 32 : s;
    endfunction

    // atan(2^-i), Q2.30, truncated
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/eabb_front.sv
module eabb_front import eabb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_item   i_item,
    output logic       o_valid,
    output t_seed_item o_seed
);

    typedef struct packed {
        logic den_zero;
        logic num_pos;
        logic num_neg;
        logic flip;
    } t_cls;

    // shift that brings the larger magnitude below 2^30
    function automatic logic [5:0] norm_shift(input logic [61:0] v);
        logic [5:0] s;
        s = '0;
        for (int b = 30; b < 62; b++) begin
            if (v[b]) s = 6'(b - 29);
        end
        return s;
    endfunction

    logic               r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    t_in_item           r_f1_item, r_f2_item, r_f3_item;
    logic signed [63:0] r_f1_num [2];
    logic signed [63:0] r_f1_den [2];
    logic [61:0]        r_f2_mn [2];
    logic [61:0]        r_f2_md [2];
    logic [61:0]        r_f3_mn [2];
    logic [61:0]        r_f3_md [2];
    logic [5:0]         r_f3_sh [2];
    t_cls               r_f2_cls [2];
    t_cls               r_f3_cls [2];
    t_seed_item         r_f4_seed;

    logic signed [31:0] w_rx, w_ry;
    assign w_rx = $signed({1'b0, i_item.radius_x});
    assign w_ry = $signed({1'b0, i_item.radius_y});

    // products: numerator ry*c / ry*d, denominator rx*a / rx*b
    always_ff @(posedge i_clk) begin
        r_f1_item   <= i_item;
        r_f1_num[0] <= w_ry * i_item.xform_c;
        r_f1_den[0] <= w_rx * i_item.xform_a;
        r_f1_num[1] <= w_ry * i_item.xform_d;
        r_f1_den[1] <= w_rx * i_item.xform_b;
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= i_valid;
        end
    end

    // classify and take magnitudes
    always_ff @(posedge i_clk) begin
        r_f2_item <= r_f1_item;
        for (int k = 0; k < 2; k++) begin
            r_f2_mn[k] <= r_f1_num[k][63] ? 62'(-r_f1_num[k]) : r_f1_num[k][61:0];
            r_f2_md[k] <= r_f1_den[k][63] ? 62'(-r_f1_den[k]) : r_f1_den[k][61:0];
            r_f2_cls[k].den_zero <= (r_f1_den[k] == '0);
            r_f2_cls[k].num_neg  <= r_f1_num[k][63];
            r_f2_cls[k].num_pos  <= !r_f1_num[k][63] && (r_f1_num[k] != '0);
            r_f2_cls[k].flip     <= r_f1_num[k][63] != r_f1_den[k][63];
        end
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f3_item <= r_f2_item;
        for (int k = 0; k < 2; k++) begin
            r_f3_mn[k]  <= r_f2_mn[k];
            r_f3_md[k]  <= r_f2_md[k];
            r_f3_cls[k] <= r_f2_cls[k];
            r_f3_sh[k]  <= norm_shift(r_f2_mn[k] | r_f2_md[k]);
        end
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else begin
            r_f3_v <= r_f2_v;
        end
    end

    logic [61:0]          w_mn_sh [2];
    logic [61:0]          w_md_sh [2];
    logic signed [CW-1:0] w_ymag [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_mn_sh[k] = r_f3_mn[k] >> r_f3_sh[k];
            w_md_sh[k] = r_f3_md[k] >> r_f3_sh[k];
            w_ymag[k]  = $signed({{(CW-30){1'b0}}, w_mn_sh[k][29:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_f4_seed.item <= r_f3_item;
        for (int k = 0; k < 2; k++) begin
            r_f4_seed.lane[k].x        <= $signed({{(CW-30){1'b0}}, w_md_sh[k][29:0]});
            r_f4_seed.lane[k].y        <= r_f3_cls[k].flip ? -w_ymag[k] : w_ymag[k];
            r_f4_seed.lane[k].den_zero <= r_f3_cls[k].den_zero;
            r_f4_seed.lane[k].num_pos  <= r_f3_cls[k].num_pos;
            r_f4_seed.lane[k].num_neg  <= r_f3_cls[k].num_neg;
        end
        if (!i_rst_n) begin
            r_f4_v <= 1'b0;
        end else begin
            r_f4_v <= r_f3_v;
        end
    end

    assign o_valid = r_f4_v;
    assign o_seed  = r_f4_seed;

endmodule

FILE: hw/rtl/eabb_queue.sv
module eabb_queue import eabb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_seed_item i_data,
    output logic       o_valid,
    output t_seed_item o_data,
    output logic       o_full
);

    t_seed_item      r_mem [Q_DEPTH];
    t_seed_item      r_dout;
    logic [Q_AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            r_dv;
    logic            w_pop;

    // the back end never stalls: drain one word whenever one is stored
    assign w_pop = (r_cnt != '0);

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (w_pop) begin
            r_dout <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_dv  <= 1'b0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
            r_dv  <= w_pop;
        end
    end

    // leave room for every word still inside the front end
    assign o_full  = (r_cnt >= (Q_AW+1)'(Q_DEPTH - FRONT_STAGES));
    assign o_valid = r_dv;
    assign o_data  = r_dout;

endmodule

FILE: hw/rtl/eabb_back.sv
module eabb_back import eabb_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_seed_item i_seed,
    output logic       o_valid,
    output t_out_item  o_result
);

    localparam int N = steps_used(STEPS);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 den_zero;
        logic                 num_pos;
        logic                 num_neg;
    } t_vlane;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_rlane;

    function automatic logic signed [CW-1:0] tab(input int sh);
        return $signed({{(CW-30){1'b0}}, atan_entry(5'(sh))});
    endfunction

    function automatic t_vlane vec_step(input t_vlane l, input int sh);
        t_vlane o;
        o = l;
        if (!l.y[CW-1]) begin
            o.x = l.x + (l.y >>> sh);
            o.y = l.y - (l.x >>> sh);
            o.z = l.z + tab(sh);
        end else begin
            o.x = l.x - (l.y >>> sh);
            o.y = l.y + (l.x >>> sh);
            o.z = l.z - tab(sh);
        end
        return o;
    endfunction

    function automatic t_rlane rot_step(input t_rlane l, input int sh);
        t_rlane o;
        if (!l.z[CW-1]) begin
            o.x = l.x - (l.y >>> sh);
            o.y = l.y + (l.x >>> sh);
            o.z = l.z - tab(sh);
        end else begin
            o.x = l.x + (l.y >>> sh);
            o.y = l.y - (l.x >>> sh);
            o.z = l.z + tab(sh);
        end
        return o;
    endfunction

    function automatic logic signed [CW-1:0] rnd30(input logic signed [65:0] p,
                                                   input logic neg);
        logic signed [67:0] v;
        v = 68'(p);
        if (neg) v = -v;
        v = v + 68'sd536870912;
        return CW'(v >>> 30);
    endfunction

    function automatic logic signed [W_PT-1:0] rnd24(input logic signed [65:0] p);
        logic signed [67:0] v;
        v = 68'(p) + 68'sd8388608;
        return W_PT'(v >>> 24);
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [W_F-1:0] v);
        logic signed [31:0] r;
        if (v > W_F'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < W_F'(-64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] sat_u31(input logic signed [W_F-1:0] v);
        logic [30:0] r;
        if (v > W_F'(64'sd2147483647)) begin
            r = 31'h7FFF_FFFF;
        end else if (v[W_F-1]) begin
            r = '0;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    // ---------------- vectoring: one CORDIC step per stage ----------------
    logic         r_vv    [1:N];
    t_in_item     r_vitem [1:N];
    t_vlane [1:0] r_vl    [1:N];

    for (genvar g = 0; g < N; g++) begin : g_vec
        logic         v_in;
        t_in_item     it_in;
        t_vlane [1:0] l_in;
        if (g == 0) begin : g_src
            assign v_in  = i_valid;
            assign it_in = i_seed.item;
            always_comb begin
                for (int k = 0; k < 2; k++) begin
                    l_in[k].x        = i_seed.lane[k].x;
                    l_in[k].y        = i_seed.lane[k].y;
                    l_in[k].z        = '0;
                    l_in[k].den_zero = i_seed.lane[k].den_zero;
                    l_in[k].num_pos  = i_seed.lane[k].num_pos;
                    l_in[k].num_neg  = i_seed.lane[k].num_neg;
                end
            end
        end else begin : g_mid
            assign v_in  = r_vv[g];
            assign it_in = r_vitem[g];
            assign l_in  = r_vl[g];
        end
        always_ff @(posedge i_clk) begin
            r_vitem[g+1] <= it_in;
            for (int k = 0; k < 2; k++) begin
                r_vl[g+1][k] <= vec_step(l_in[k], g);
            end
            if (!i_rst_n) begin
                r_vv[g+1] <= 1'b0;
            end else begin
                r_vv[g+1] <= v_in;
            end
        end
    end

    // ---------------- rotation: cos/sin of each angle ----------------
    logic         r_rv    [1:N];
    t_in_item     r_ritem [1:N];
    t_rlane [1:0] r_rl    [1:N];

    for (genvar g = 0; g < N; g++) begin : g_rot
        logic         v_in;
        t_in_item     it_in;
        t_rlane [1:0] l_in;
        if (g == 0) begin : g_src
            assign v_in  = r_vv[N];
            assign it_in = r_vitem[N];
            // zero denominator takes a right angle by the numerator's sign
            always_comb begin
                for (int k = 0; k < 2; k++) begin
                    l_in[k].x = ROT_GAIN;
                    l_in[k].y = '0;
                    if (r_vl[N][k].den_zero) begin
                        l_in[k].z = r_vl[N][k].num_pos ? ANG_HALF_PI :
                                    r_vl[N][k].num_neg ? -ANG_HALF_PI : '0;
                    end else begin
                        l_in[k].z = r_vl[N][k].z;
                    end
                end
            end
        end else begin : g_mid
            assign v_in  = r_rv[g];
            assign it_in = r_ritem[g];
            assign l_in  = r_rl[g];
        end
        always_ff @(posedge i_clk) begin
            r_ritem[g+1] <= it_in;
            for (int k = 0; k < 2; k++) begin
                r_rl[g+1][k] <= rot_step(l_in[k], g);
            end
            if (!i_rst_n) begin
                r_rv[g+1] <= 1'b0;
            end else begin
                r_rv[g+1] <= v_in;
            end
        end
    end

    // ---------------- mapping and box ----------------
    logic                   r_m1v, r_m2v, r_m3v, r_m4v, r_m5v, r_m6v, r_m7v;
    t_in_item               r_m1i, r_m2i, r_m3i, r_m4i, r_m5i, r_m6i;
    logic signed [65:0]     r_pc [2];
    logic signed [65:0]     r_ps [2];
    logic signed [CW-1:0]   r_ux [4];
    logic signed [CW-1:0]   r_uy [4];
    logic signed [65:0]     r_acx, r_ccy, r_bcx, r_dcy;
    logic signed [65:0]     r_aux [4];
    logic signed [65:0]     r_cuy [4];
    logic signed [65:0]     r_bux [4];
    logic signed [65:0]     r_duy [4];
    logic signed [W_PT-1:0] r_px [4];
    logic signed [W_PT-1:0] r_py [4];
    logic signed [W_PT-1:0] r_lox [2];
    logic signed [W_PT-1:0] r_hix [2];
    logic signed [W_PT-1:0] r_loy [2];
    logic signed [W_PT-1:0] r_hiy [2];
    logic signed [W_PT-1:0] r_minx, r_maxx, r_miny, r_maxy;
    t_out_item              r_out;

    logic signed [31:0]  w_rx, w_ry;
    logic signed [W_F-1:0] w_half, w_full, w_left, w_top, w_w, w_h;

    assign w_rx = $signed({1'b0, r_ritem[N].radius_x});
    assign w_ry = $signed({1'b0, r_ritem[N].radius_y});

    always_comb begin
        w_full = r_m6i.stroke_enabled ? $signed({{(W_F-31){1'b0}}, r_m6i.stroke_size})
                                      : '0;
        w_half = w_full >>> 1;
        w_left = W_F'(r_minx) - w_half;
        w_top  = W_F'(r_miny) - w_half;
        w_w    = W_F'(r_maxx) - W_F'(r_minx) + w_full;
        w_h    = W_F'(r_maxy) - W_F'(r_miny) + w_full;
    end

    always_ff @(posedge i_clk) begin
        // radius times cos/sin
        r_m1i <= r_ritem[N];
        for (int k = 0; k < 2; k++) begin
            r_pc[k] <= w_rx * r_rl[N][k].x;
            r_ps[k] <= w_ry * r_rl[N][k].y;
        end
        // round; points two and three are the same angles plus pi
        r_m2i <= r_m1i;
        for (int k = 0; k < 2; k++) begin
            r_ux[k]   <= rnd30(r_pc[k], 1'b0);
            r_uy[k]   <= rnd30(r_ps[k], 1'b0);
            r_ux[k+2] <= rnd30(r_pc[k], 1'b1);
            r_uy[k+2] <= rnd30(r_ps[k], 1'b1);
        end
        // matrix products
        r_m3i <= r_m2i;
        r_acx <= 66'(r_m2i.xform_a * r_m2i.center_x);
        r_ccy <= 66'(r_m2i.xform_c * r_m2i.center_y);
        r_bcx <= 66'(r_m2i.xform_b * r_m2i.center_x);
        r_dcy <= 66'(r_m2i.xform_d * r_m2i.center_y);
        for (int j = 0; j < 4; j++) begin
            r_aux[j] <= r_m2i.xform_a * r_ux[j];
            r_cuy[j] <= r_m2i.xform_c * r_uy[j];
            r_bux[j] <= r_m2i.xform_b * r_ux[j];
            r_duy[j] <= r_m2i.xform_d * r_uy[j];
        end
        // round each product on its own, then add with translation
        r_m4i <= r_m3i;
        for (int j = 0; j < 4; j++) begin
            r_px[j] <= rnd24(r_acx) + rnd24(r_aux[j]) + rnd24(r_ccy) + rnd24(r_cuy[j])
                     + W_PT'(r_m3i.xform_e);
            r_py[j] <= rnd24(r_bcx) + rnd24(r_bux[j]) + rnd24(r_dcy) + rnd24(r_duy[j])
                     + W_PT'(r_m3i.xform_f);
        end
        // min/max tree
        r_m5i <= r_m4i;
        for (int p = 0; p < 2; p++) begin
            r_lox[p] <= (r_px[2*p] < r_px[2*p+1]) ? r_px[2*p] : r_px[2*p+1];
            r_hix[p] <= (r_px[2*p] > r_px[2*p+1]) ? r_px[2*p] : r_px[2*p+1];
            r_loy[p] <= (r_py[2*p] < r_py[2*p+1]) ? r_py[2*p] : r_py[2*p+1];
            r_hiy[p] <= (r_py[2*p] > r_py[2*p+1]) ? r_py[2*p] : r_py[2*p+1];
        end
        r_m6i  <= r_m5i;
        r_minx <= (r_lox[0] < r_lox[1]) ? r_lox[0] : r_lox[1];
        r_maxx <= (r_hix[0] > r_hix[1]) ? r_hix[0] : r_hix[1];
        r_miny <= (r_loy[0] < r_loy[1]) ? r_loy[0] : r_loy[1];
        r_maxy <= (r_hiy[0] > r_hiy[1]) ? r_hiy[0] : r_hiy[1];
        // stroke and saturation
        r_out.box_left   <= sat_s32(w_left);
        r_out.box_top    <= sat_s32(w_top);
        r_out.box_width  <= sat_u31(w_w);
        r_out.box_height <= sat_u31(w_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
            r_m4v <= 1'b0;
            r_m5v <= 1'b0;
            r_m6v <= 1'b0;
            r_m7v <= 1'b0;
        end else begin
            r_m1v <= r_rv[N];
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
            r_m4v <= r_m3v;
            r_m5v <= r_m4v;
            r_m6v <= r_m5v;
            r_m7v <= r_m6v;
        end
    end

    assign o_valid  = r_m7v;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/ellipse_affine_bounding_box_top.sv
// Throughput: one word per cycle; the back end never stalls, so busy stays low in use.
// Rate is set by the fully pipelined CORDIC (one stage per step, two angles side by side).
// Reset: i_rst_n is synchronous, active low; it empties every pipeline stage and the queue.
// The receiver cannot stall: each result shows on o_result for one cycle with o_done.
module ellipse_affine_bounding_box_top import eabb_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    // Front end: form ry*c, rx*a, ry*d, rx*b, flag the zero-denominator
    // cases and normalize each ratio so both magnitudes sit below 2^30.
    logic       w_accept;
    logic       w_fq_valid;
    t_seed_item w_fq_word;

    // Queue output feeds the back end.
    logic       w_bq_valid;
    t_seed_item w_bq_word;
    logic       w_q_full;

    // Take a word when start is high and the queue has room for everything
    // still in flight through the front end.
    assign w_accept = start && !busy;
    assign busy     = w_q_full;

    eabb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .o_valid (w_fq_valid),
        .o_seed  (w_fq_word)
    );

    // Short queue decoupling classification from the CORDIC back end.
    eabb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .i_data  (w_fq_word),
        .o_valid (w_bq_valid),
        .o_data  (w_bq_word),
        .o_full  (w_q_full)
    );

    // Back end: vectoring CORDIC gives both extreme angles, rotation CORDIC
    // gives cos/sin, then the four points go through the matrix, the
    // min/max box is formed, the stroke is added and the edges saturate.
    eabb_back #(
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_bq_valid),
        .i_seed   (w_bq_word),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule

FILE: hw/rtl/eabb_checker.sv
`include "assert_macros.svh"

module eabb_checker import eabb_pkg::*; #(
    parameter int STEPS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    localparam int LAT = LAT_FIXED + 2 * steps_used(STEPS);

    // no strobe comes out right after reset
    `EABB_ASSERT_RAW(a_rst_quiet, !i_rst_n |=> !o_done, "result strobe after reset")
    // every accepted word returns after the fixed latency
    `EABB_ASSERT(a_latency, (start && !busy) |-> ##LAT o_done, "accepted word lost")
    // no result without a matching accepted word
    `EABB_ASSERT(a_no_orphan, o_done |-> $past(start && !busy, LAT), "result without word")
    // the queue drains a word whenever one is stored, so it never pushes back
    `EABB_ASSERT(a_never_busy, !busy, "busy raised")

endmodule

bind ellipse_affine_bounding_box_top eabb_checker #(
    .STEPS (CORDIC_STEPS)
) u_eabb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
